FILE: hdl/rgb_to_hsv_integer_assert.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_integer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_INTEGER_ASSERT_SVH
`define RGB_TO_HSV_INTEGER_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define RGBHSV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Trigger must be followed by cond a fixed number of cycles later
`define RGBHSV_ASSERT_LAT(label, trig, cond, n, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) trig |-> ##n cond) \
        else $error(msg);

`endif

FILE: hdl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants shared by the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int PIX_W   = 8;            // channel / result width
    localparam int REM_W   = 2 * PIX_W;    // partial remainder width
    localparam int STEPS   = PIX_W;        // one quotient bit per cell
    localparam int LATENCY = STEPS + 2;    // prep stage + cells + output stage

    localparam logic [PIX_W-1:0] SAT_SCALE  = 8'd255;
    localparam logic [5:0]       HUE_SCALE  = 6'd43;
    localparam logic [PIX_W-1:0] BASE_RED   = 8'd0;
    localparam logic [PIX_W-1:0] BASE_GREEN = 8'd85;
    localparam logic [PIX_W-1:0] BASE_BLUE  = 8'd171;

    // Word handed from cell to cell: two dividers plus sideband
    typedef struct packed {
        logic [REM_W-1:0] sat_rem;   // 255*span, reduced step by step
        logic [PIX_W-1:0] sat_den;   // max channel
        logic [PIX_W-1:0] sat_quo;
        logic [REM_W-1:0] hue_rem;   // 43*|diff|, reduced step by step
        logic [PIX_W-1:0] hue_den;   // span = max - min
        logic [PIX_W-1:0] hue_quo;
        logic [PIX_W-1:0] base;      // hue sector base
        logic             neg;       // channel difference was negative
        logic [PIX_W-1:0] value;     // max channel, passed through
        logic             chroma;    // span is nonzero
    } rgbhsv_word_t;

endpackage

FILE: hdl/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// rgbhsv_prep
// Front stage: max/min, sector select and scaled dividends for the cell row.
// ----------------------------------------------------------------------------
module rgbhsv_prep (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    output logic                      out_valid,
    output rgbhsv_pkg::rgbhsv_word_t  out_word
);
    import rgbhsv_pkg::*;

    logic             valid_reg;
    rgbhsv_word_t     word_reg;
    rgbhsv_word_t     word_next;

    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] span;
    logic [PIX_W-1:0] pos_a;
    logic [PIX_W-1:0] pos_b;
    logic [PIX_W-1:0] mag;
    logic [PIX_W-1:0] base;

    // Extremes of the three channels
    always_comb
    begin
        hi = (red > green) ? red : green;
        hi = (hi > blue) ? hi : blue;
        lo = (red < green) ? red : green;
        lo = (lo < blue) ? lo : blue;
        span = hi - lo;
    end

    // Sector: red first, then green, then blue on ties
    always_comb
    begin
        if (hi == red)
        begin
            base  = BASE_RED;
            pos_a = green;
            pos_b = blue;
        end
        else if (hi == green)
        begin
            base  = BASE_GREEN;
            pos_a = blue;
            pos_b = red;
        end
        else
        begin
            base  = BASE_BLUE;
            pos_a = red;
            pos_b = green;
        end
        mag = (pos_a >= pos_b) ? (pos_a - pos_b) : (pos_b - pos_a);
    end

    // Word for the first cell; 43*|diff| needs the full remainder width
    always_comb
    begin
        word_next.sat_rem = ({span, 8'd0}) - REM_W'(span);
        word_next.sat_den = hi;
        word_next.sat_quo = '0;
        word_next.hue_rem = REM_W'(mag) * REM_W'(HUE_SCALE);
        word_next.hue_den = span;
        word_next.hue_quo = '0;
        word_next.base    = base;
        word_next.neg     = (pos_a < pos_b);
        word_next.value   = hi;
        word_next.chroma  = (span != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: hdl/rgbhsv_cell.sv
// ----------------------------------------------------------------------------
// rgbhsv_cell
// One restoring-division step for both dividers; yields one quotient bit each.
// ----------------------------------------------------------------------------
module rgbhsv_cell #(
    parameter int STEP = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  rgbhsv_pkg::rgbhsv_word_t  in_word,
    output logic                      out_valid,
    output rgbhsv_pkg::rgbhsv_word_t  out_word
);
    import rgbhsv_pkg::*;

    logic             valid_reg;
    rgbhsv_word_t     word_reg;
    rgbhsv_word_t     word_next;
    logic [REM_W-1:0] sat_sub;
    logic [REM_W-1:0] hue_sub;

    // Divisors aligned to this cell's quotient bit
    assign sat_sub = REM_W'(in_word.sat_den) << STEP;
    assign hue_sub = REM_W'(in_word.hue_den) << STEP;

    // Compare and subtract
    always_comb
    begin
        word_next = in_word;
        if (in_word.sat_rem >= sat_sub)
        begin
            word_next.sat_rem       = in_word.sat_rem - sat_sub;
            word_next.sat_quo[STEP] = 1'b1;
        end
        if (in_word.hue_rem >= hue_sub)
        begin
            word_next.hue_rem       = in_word.hue_rem - hue_sub;
            word_next.hue_quo[STEP] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: hdl/rgb_to_hsv_integer.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_integer
// 8-bit RGB to 8-bit HSV converter built as a row of division cells.
// ----------------------------------------------------------------------------
//  Channel   Handshake      Word
//  input     start / busy   red, green, blue
//  output    done           hue, saturation, brightness
//
//  One pixel per clock; each result shows on done once its start has passed
//  the prep stage, eight division cells (one quotient bit each
//  for saturation and hue) and the output register.
//  busy stays low: the row never stalls, and the receiver cannot stall.
//  Reset clears the valid bits of all stages; words in flight are dropped.
// ----------------------------------------------------------------------------
module rgb_to_hsv_integer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       done,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] brightness
);
    import rgbhsv_pkg::*;

    logic             accept;
    logic             valid_chain [0:STEPS];
    rgbhsv_word_t     word_chain  [0:STEPS];
    rgbhsv_word_t     last_word;
    logic [PIX_W-1:0] offs;

    logic             done_reg;
    logic [PIX_W-1:0] hue_reg;
    logic [PIX_W-1:0] hue_next;
    logic [PIX_W-1:0] sat_reg;
    logic [PIX_W-1:0] sat_next;
    logic [PIX_W-1:0] bright_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Front stage
    rgbhsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (valid_chain[0]),
        .out_word  (word_chain[0])
    );

    // Row of division cells, MSB quotient bit first
    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        rgbhsv_cell #(
            .STEP (STEPS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[k]),
            .in_word   (word_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_word  (word_chain[k+1])
        );
    end

    assign last_word = word_chain[STEPS];

    // Signed offset, base add with wrap, gray/black masking
    always_comb
    begin
        offs     = last_word.neg ? (~last_word.hue_quo + 8'd1) : last_word.hue_quo;
        hue_next = last_word.chroma ? (last_word.base + offs) : '0;
        sat_next = last_word.chroma ? last_word.sat_quo : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_chain[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sat_reg    <= sat_next;
        bright_reg <= last_word.value;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

FILE: hdl/rgbhsv_chk.sv
// ----------------------------------------------------------------------------
// rgbhsv_chk
// Port-level checks of the converter: latency and result consistency.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_integer_assert.svh"

module rgbhsv_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic       done,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] brightness
);
    import rgbhsv_pkg::*;

    logic       taken;
    logic       black_out;
    logic       zero_hs;
    logic [7:0] max_in;

    assign taken     = start & ~busy & rst_n;
    assign black_out = done && (brightness == 8'd0);
    assign zero_hs   = (hue == 8'd0) && (saturation == 8'd0);

    // Largest channel of the word on the inputs
    always_comb
    begin
        max_in = (red > green) ? red : green;
        max_in = (max_in > blue) ? max_in : blue;
    end

    // Every accepted word comes out after the fixed latency
    `RGBHSV_ASSERT_LAT(a_lat_fwd, taken, done, LATENCY, "accepted word did not complete on time")
    // No result without an accepted word behind it
    `RGBHSV_ASSERT(a_lat_back, done |-> $past(taken, LATENCY), "done without accepted word")
    // Black pixel gives zero hue and saturation
    `RGBHSV_ASSERT(a_black, black_out |-> zero_hs, "black pixel not zeroed")
    // Brightness is the largest channel of the matching input
    `RGBHSV_ASSERT(a_value, done |-> (brightness == $past(max_in, LATENCY)), "bad brightness")

endmodule

bind rgb_to_hsv_integer rgbhsv_chk u_chk (.*);
